// ----- sv/opab_pkg.sv -----
// ----------------------------------------------------------------------------
// opab_pkg
// shared types, codes and channel arithmetic for the overlay alpha blender
// ----------------------------------------------------------------------------
`default_nettype none

package opab_pkg;

    localparam int unsigned PIX_W = 32;
    localparam int unsigned CH_W  = 8;
    localparam int unsigned IDX_W = 2;

    // opcodes
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_RECT = 1'b1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_FG   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_BG   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FILL = 2'd2;

    // reset colours
    localparam logic [PIX_W-1:0] FG_RST   = 32'h00FF_FFFF;
    localparam logic [PIX_W-1:0] BG_RST   = 32'hFF00_0000;
    localparam logic [PIX_W-1:0] FILL_RST = 32'h0000_0000;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'h00;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'hFF;

    typedef struct packed {
        logic [PIX_W-1:0] fg;
        logic [PIX_W-1:0] bg;
        logic [PIX_W-1:0] fill;
    } t_colours;

    // (ch * m) >> 8
    function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] ch,
                                                 input logic [CH_W-1:0] m);
        logic [2*CH_W-1:0] prod;
        prod = ch * m;
        return prod[2*CH_W-1:CH_W];
    endfunction

    // channels scaled by (255 - alpha) unless alpha is opaque or clear
    function automatic logic [PIX_W-1:0] premultiply(input logic [PIX_W-1:0] c);
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] m;
        a = c[31:24];
        m = ALPHA_CLEAR - a;
        if (a == ALPHA_OPAQUE || a == ALPHA_CLEAR) begin
            return c;
        end
        return {a, scale_ch(c[23:16], m), scale_ch(c[15:8], m), scale_ch(c[7:0], m)};
    endfunction

endpackage

`default_nettype wire

// ----- sv/opab_cfg.sv -----
// ----------------------------------------------------------------------------
// opab_cfg
// colour registers, stored already premultiplied on write
// ----------------------------------------------------------------------------
`default_nettype none

module opab_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [opab_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [opab_pkg::PIX_W-1:0]    i_cfg_data,
    output opab_pkg::t_colours                 o_colours
);

    opab_pkg::t_colours        r_colours;
    logic [opab_pkg::PIX_W-1:0] n_pm;

    assign n_pm = opab_pkg::premultiply(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colours.fg   <= opab_pkg::FG_RST;
            r_colours.bg   <= opab_pkg::BG_RST;
            r_colours.fill <= opab_pkg::FILL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                opab_pkg::CFG_FG:   r_colours.fg   <= n_pm;
                opab_pkg::CFG_BG:   r_colours.bg   <= n_pm;
                opab_pkg::CFG_FILL: r_colours.fill <= n_pm;
                default: begin
                end
            endcase
        end
    end

    assign o_colours = r_colours;

endmodule

`default_nettype wire

// ----- sv/opab_blend.sv -----
// ----------------------------------------------------------------------------
// opab_blend
// input register, colour select and blend, result register
// ----------------------------------------------------------------------------
`default_nettype none

module opab_blend (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire opab_pkg::t_colours            i_colours,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_opcode,
    input  wire logic                          i_glyph_bit,
    input  wire logic [opab_pkg::PIX_W-1:0]    i_dest_pixel,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_write_enable,
    output logic [opab_pkg::PIX_W-1:0]         o_pixel_out
);

    logic                          r_in_valid;
    logic                          r_in_opcode;
    logic                          r_in_glyph;
    logic [opab_pkg::PIX_W-1:0]    r_in_dest;
    logic                          r_out_valid;
    logic                          r_out_we;
    logic [opab_pkg::PIX_W-1:0]    r_out_pixel;

    logic                          out_free;
    logic [opab_pkg::PIX_W-1:0]    colour;
    logic [opab_pkg::CH_W-1:0]     alpha;
    logic [opab_pkg::PIX_W-1:0]    dest_scaled;
    logic [opab_pkg::PIX_W-1:0]    blended;
    logic                          n_we;
    logic [opab_pkg::PIX_W-1:0]    n_pixel;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_opcode <= i_opcode;
            r_in_glyph  <= i_glyph_bit;
            r_in_dest   <= i_dest_pixel;
        end
    end

    always_comb begin
        if (r_in_opcode == opab_pkg::OP_RECT) begin
            colour = i_colours.fill;
        end else if (r_in_glyph) begin
            colour = i_colours.fg;
        end else begin
            colour = i_colours.bg;
        end
    end

    assign alpha       = colour[31:24];
    assign dest_scaled = {8'h00,
                          opab_pkg::scale_ch(r_in_dest[23:16], alpha),
                          opab_pkg::scale_ch(r_in_dest[15:8], alpha),
                          opab_pkg::scale_ch(r_in_dest[7:0], alpha)};
    assign blended     = {8'h00, colour[23:0]} + dest_scaled;

    always_comb begin
        n_we    = 1'b1;
        n_pixel = blended;
        if (r_in_opcode == opab_pkg::OP_TEXT) begin
            if (alpha == opab_pkg::ALPHA_OPAQUE) begin
                n_pixel = colour;
            end else if (alpha == opab_pkg::ALPHA_CLEAR) begin
                n_we    = 1'b0;
                n_pixel = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_out_we    <= n_we;
            r_out_pixel <= n_pixel;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_pixel_out    = r_out_pixel;

`ifndef SYNTHESIS
    a_suppressed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_we |-> r_out_pixel == '0)
        else $error("suppressed write carries non-zero pixel");

    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_in_valid)
        else $error("accepted transfer not held in input register");

    a_in_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_free |=> r_out_valid)
        else $error("input register did not advance to result register");

    a_blend_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_pixel[31:25] == '0 || r_out_we)
        else $error("unexpected high pixel bits on suppressed write");
`endif

endmodule

`default_nettype wire

// ----- sv/overlay_pixel_alpha_blend.sv -----
// ----------------------------------------------------------------------------
// overlay_pixel_alpha_blend
// pipeline: an input transfer is held in the input reg, its result then in the result reg
// throughput: 1 pixel per cycle unless i_ready stalls the output, set by the single blend stage between them
// colours are premultiplied as they are written, so a pixel needs one pass
// reset: synchronous active low, clears both valid flags and loads reset colours
// ----------------------------------------------------------------------------
`default_nettype none

module overlay_pixel_alpha_blend (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [opab_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [opab_pkg::PIX_W-1:0]    i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_opcode,
    input  wire logic                          i_glyph_bit,
    input  wire logic [opab_pkg::PIX_W-1:0]    i_dest_pixel,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_write_enable,
    output logic [opab_pkg::PIX_W-1:0]         o_pixel_out
);

    opab_pkg::t_colours colours;

    opab_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_colours  (colours)
    );

    opab_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_colours      (colours),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_glyph_bit    (i_glyph_bit),
        .i_dest_pixel   (i_dest_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_pixel_out    (o_pixel_out)
    );

endmodule

`default_nettype wire
